// File: rtl/core/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared constants, types and helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

  // Longest expansion of one input byte: open quote, six-byte escape, close quote.
  localparam int MaxRes = 8;
  localparam int CntW   = $clog2(MaxRes + 1);
  localparam int EscMax = 6;

  // Characters used by the escaper.
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] CtrlLim  = 8'd32;
  localparam logic [7:0] DelByte  = 8'd127;

  // Escaped text of one input item, first byte in the lowest slot.
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [CntW-1:0]        len;
    logic                   close;
  } enc_seq_t;

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return ChZero + {4'h0, nib};
    end
    return 8'h57 + {4'h0, nib};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/jse_encoder.sv
// ----------------------------------------------------------------------------
// jse_encoder
// Turns one input byte and its string markers into the escaped byte sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_encoder (
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             string_start_i,
  input  wire logic             string_end_i,
  input  wire logic             empty_string_i,
  output jse_pkg::enc_seq_t     seq_o
);
  import jse_pkg::*;

  logic [EscMax-1:0][7:0] esc;
  logic [CntW-1:0]        esc_len;
  logic [CntW-1:0]        pos;
  logic [CntW-1:0]        start_w;
  logic [CntW-1:0]        end_w;

  // Escape form of the data byte alone.
  always_comb begin
    esc     = '0;
    esc_len = CntW'(1);
    if (data_byte_i inside {ChQuote, ChBslash, ChSlash}) begin
      esc[0]  = ChBslash;
      esc[1]  = data_byte_i;
      esc_len = CntW'(2);
    end else if (data_byte_i == ChLf) begin
      esc[0]  = ChBslash;
      esc[1]  = ChN;
      esc_len = CntW'(2);
    end else if (data_byte_i == ChCr) begin
      esc[0]  = ChBslash;
      esc[1]  = ChR;
      esc_len = CntW'(2);
    end else if (data_byte_i < CtrlLim || data_byte_i > DelByte) begin
      esc[0]  = ChBslash;
      esc[1]  = ChU;
      esc[2]  = ChZero;
      esc[3]  = ChZero;
      esc[4]  = hex_digit(data_byte_i[7:4]);
      esc[5]  = hex_digit(data_byte_i[3:0]);
      esc_len = CntW'(EscMax);
    end else begin
      esc[0]  = data_byte_i;
    end
  end

  assign start_w = {{(CntW-1){1'b0}}, string_start_i};
  assign end_w   = {{(CntW-1){1'b0}}, string_end_i};

  // Place the optional quotes around the escape; an empty string is two quotes.
  always_comb begin
    seq_o = '0;
    pos   = '0;
    if (empty_string_i) begin
      seq_o.bytes[0] = ChQuote;
      seq_o.bytes[1] = ChQuote;
      seq_o.len      = CntW'(2);
      seq_o.close    = 1'b1;
    end else begin
      for (int i = 0; i < MaxRes; i++) begin
        pos = CntW'(i) - start_w;
        if (string_start_i && i == 0) begin
          seq_o.bytes[i] = ChQuote;
        end else if (pos < esc_len) begin
          seq_o.bytes[i] = esc[pos[$clog2(EscMax)-1:0]];
        end else begin
          seq_o.bytes[i] = ChQuote;
        end
      end
      seq_o.len   = start_w + esc_len + end_w;
      seq_o.close = string_end_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/jse_serializer.sv
// ----------------------------------------------------------------------------
// jse_serializer
// Holds one escaped sequence and shifts it out one byte per output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_serializer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire jse_pkg::enc_seq_t seq_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   run_last_o,
  output logic                   string_done_o
);
  import jse_pkg::*;

  logic [MaxRes-1:0][7:0] seq_q, seq_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   close_q, close_d;
  logic                   out_xfer;
  logic                   in_xfer;
  logic                   last_byte;

  assign last_byte  = (cnt_q == CntW'(1));
  assign out_valid_o = (cnt_q != '0);
  assign out_xfer   = out_valid_o && !out_stall_i;
  // A new item may load as the final byte of the current one leaves.
  assign in_stall_o = out_valid_o && !(last_byte && out_xfer);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Next sequence: load a new item or shift out the byte just taken.
  always_comb begin
    seq_d   = seq_q;
    cnt_d   = cnt_q;
    close_d = close_q;
    if (in_xfer) begin
      seq_d   = seq_i.bytes;
      cnt_d   = seq_i.len;
      close_d = seq_i.close;
    end else if (out_xfer) begin
      seq_d   = seq_q >> 8;
      cnt_d   = cnt_q - CntW'(1);
    end
  end

  // Byte count is control state; the byte slots are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      close_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      close_q <= close_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
  end

  assign out_byte_o    = seq_q[0];
  assign run_last_o    = last_byte;
  assign string_done_o = last_byte && close_q;

  // The count never exceeds the longest expansion.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(MaxRes))
    else $error("byte count out of range");

  // The closing quote is always the last byte of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    string_done_o |-> (run_last_o && out_byte_o == ChQuote))
    else $error("string_done on a byte other than a final quote");

  // Taking a byte that is not the last leaves more bytes to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !last_byte) |=> out_valid_o)
    else $error("sequence ended early");

  // Input is never taken while non-final bytes remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_byte) |-> !in_xfer)
    else $error("item loaded over a pending sequence");

endmodule

`default_nettype wire

// File: rtl/core/json_string_escaper_top.sv
// ----------------------------------------------------------------------------
// json_string_escaper_top
// Escapes a byte string into JSON-quoted text, one output byte per cycle while
// out_stall_i is low. An accepted byte shows its first output byte in the next
// cycle. An item yields 1 to 8 output bytes on the single output byte lane; the
// next item loads as its last byte leaves: one plain byte per unstalled cycle.
// Reset: asynchronous, active low; clears the pending byte count so no
// output is valid and input is accepted at once.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       string_start_i,
  input  wire logic       string_end_i,
  input  wire logic       empty_string_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_done_o
);
  import jse_pkg::*;

  enc_seq_t enc_seq;

  // Escape the incoming byte.
  jse_encoder u_enc (
    .data_byte_i    (data_byte_i),
    .string_start_i (string_start_i),
    .string_end_i   (string_end_i),
    .empty_string_i (empty_string_i),
    .seq_o          (enc_seq)
  );

  // Register the sequence and send it out byte by byte.
  jse_serializer u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .seq_i         (enc_seq),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

endmodule

`default_nettype wire
